[design/czs_pkg.sv]
// shared types, constants and sequencer states of the column z-score standardizer
package czs_pkg;

  // defaults for the top-level parameters
  localparam int unsigned ColumnDepthDefault = 64;
  localparam int unsigned SampleBitsDefault  = 16;

  // fixed field widths
  localparam int unsigned SampleFieldW = 16;
  localparam int unsigned ResultW      = 16;

  // scaled magnitude search: Q4.11 result, 2048^2 * 4 = 2^24 on the right-hand side
  localparam int unsigned ZW        = 16;
  localparam int unsigned ZBitW     = $clog2(ZW);
  localparam int unsigned FracShift = 24;
  localparam logic [ZW-1:0] ZCapPos = 16'h7fff;
  localparam logic [ZW-1:0] ZCapNeg = 16'h8000;

  // shared multiplier: 64 x 32 product in 16-bit slices of the first operand
  localparam int unsigned MulAW     = 64;
  localparam int unsigned MulBW     = 32;
  localparam int unsigned MulPW     = MulAW + MulBW;
  localparam int unsigned MulChunkW = 16;
  localparam int unsigned MulChunks = MulAW / MulChunkW;

  typedef struct packed {
    logic             valid;
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
  } mul_req_t;

  typedef enum logic [3:0] {
    StLoad,
    StRead,
    StDev,
    StSquare,
    StScale,
    StTry,
    StTrySq,
    StTryProd,
    StEmit
  } st_e;

endpackage

[design/column_zscore_standardizer_unit.sv]
// top level of the column z-score standardizer (sample standard deviation)
//
// input channel: one column sample per transfer (sample_i, last_in_column_i),
// taken while in_valid_i is high and in_stall_o is low. a column closes on the
// flagged sample or on the sample that fills the store (COLUMN_DEPTH samples).
// output channel: after a column closes, one transfer per stored sample in
// arrival order, standardized_o = (x - mean) / sd in signed Q4.11, with
// last_of_column_o on the final one and degenerate_o when the column has one
// sample or zero spread (then all results are zero).
// timing: loading takes one sample per cycle. after the closing sample the
// block stalls its input while it works: it forms the sum of squared
// deviations, then runs the 16-step rounding search for each result; nearly
// all of the work is in the shared 16 x 32 slice multiplier.
// the result register lets the block finish the next result while the
// receiver stalls; work waits only when a result is ready, the register is
// still full and the receiver stalls. reset empties the column, clears the
// sum and drops out_valid_o.
module column_zscore_standardizer_unit #(
  parameter int unsigned COLUMN_DEPTH = czs_pkg::ColumnDepthDefault,
  parameter int unsigned SAMPLE_BITS  = czs_pkg::SampleBitsDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [czs_pkg::SampleFieldW-1:0] sample_i,
  input  logic                                last_in_column_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [czs_pkg::ResultW-1:0]  standardized_o,
  output logic                                last_of_column_o,
  output logic                                degenerate_o
);

  // stored width: samples sign-extend from at most the field width
  localparam int unsigned StoreW = (SAMPLE_BITS < czs_pkg::SampleFieldW) ? SAMPLE_BITS
                                                                         : czs_pkg::SampleFieldW;
  localparam int unsigned AddrW  = $clog2(COLUMN_DEPTH);
  localparam int unsigned CntW   = $clog2(COLUMN_DEPTH + 1);
  localparam int unsigned SumW   = StoreW + CntW;
  localparam int unsigned DevW   = StoreW + CntW + 1;
  localparam int unsigned SqW    = 2 * DevW;
  localparam int unsigned SsqW   = SqW + CntW;

  czs_pkg::st_e state_q, state_d;

  // column bookkeeping
  logic [CntW-1:0]        cnt_q;
  logic signed [SumW-1:0] sum_q;
  logic [AddrW-1:0]       idx_q;
  logic                   pass_q;   // 0: squared deviation pass, 1: result pass
  logic                   degen_q;
  logic [SsqW-1:0]        ssq_q;

  // per-sample working registers
  logic [DevW-1:0]           mag_q;
  logic                      dev_neg_q;
  logic [SqW-1:0]            sq_q;
  logic [czs_pkg::MulPW-1:0] rhs_q;
  logic [czs_pkg::MulBW-1:0] tsq_q;
  logic [czs_pkg::ZW-1:0]    v_q;
  logic [czs_pkg::ZBitW-1:0] bit_q;

  // result register
  logic                              out_valid_q;
  logic signed [czs_pkg::ResultW-1:0] out_z_q;
  logic                              out_last_q;
  logic                              out_degen_q;

  // ram ports
  logic              ram_rd_en;
  logic [StoreW-1:0] ram_rd_data;
  logic              in_fire;

  // multiplier
  czs_pkg::mul_req_t         mul_req;
  logic                      mul_done;
  logic [czs_pkg::MulPW-1:0] mul_prod;

  // combinational datapath
  logic                   close_col;
  logic                   last_idx;
  logic signed [DevW-1:0] n_s, x_s, nx_w, dev_w;
  logic [DevW-1:0]        mag_w;
  logic [SsqW-1:0]        ssq_next;
  logic [czs_pkg::ZW-1:0] cand;
  logic [czs_pkg::ZW-1:0] cap;
  logic [czs_pkg::ZW-1:0] t_odd;
  logic                   cand_over;
  logic                   cand_ok;
  logic                   emit_fire;
  logic [czs_pkg::MulBW-1:0] k_scale;

  assign in_fire   = in_valid_i && (state_q == czs_pkg::StLoad);
  assign close_col = last_in_column_i || (cnt_q == CntW'(COLUMN_DEPTH - 1));
  assign last_idx  = (CntW'(idx_q) == (cnt_q - CntW'(1)));

  // deviation scaled by n: n * x - sum, exact
  assign n_s   = DevW'($signed({1'b0, cnt_q}));
  assign x_s   = DevW'($signed(ram_rd_data));
  assign nx_w  = n_s * x_s;
  assign dev_w = nx_w - DevW'(sum_q);
  assign mag_w = dev_w[DevW-1] ? DevW'(-dev_w) : DevW'(dev_w);

  assign ssq_next = ssq_q + SsqW'(mul_prod[SqW-1:0]);

  // (n - 1) * 2^24 on the right-hand side of the rounding test
  assign k_scale = czs_pkg::MulBW'({cnt_q - CntW'(1), {czs_pkg::FracShift{1'b0}}});

  // bitwise search for the largest v with (2v - 1)^2 * ssq <= dev^2 * (n - 1) * 2^24
  assign cap       = dev_neg_q ? czs_pkg::ZCapNeg : czs_pkg::ZCapPos;
  assign cand      = v_q | (czs_pkg::ZW'(1) << bit_q);
  assign cand_over = (cand > cap);
  assign t_odd     = {cand[czs_pkg::ZW-2:0], 1'b0} - czs_pkg::ZW'(1);
  assign cand_ok   = (mul_prod <= rhs_q);

  assign emit_fire = (state_q == czs_pkg::StEmit) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      czs_pkg::StLoad: begin
        if (in_fire && close_col) state_d = czs_pkg::StRead;
      end
      czs_pkg::StRead: state_d = czs_pkg::StDev;
      czs_pkg::StDev:  state_d = czs_pkg::StSquare;
      czs_pkg::StSquare: begin
        if (mul_done) begin
          if (!pass_q)      state_d = czs_pkg::StRead;
          else if (degen_q) state_d = czs_pkg::StEmit;
          else              state_d = czs_pkg::StScale;
        end
      end
      czs_pkg::StScale: begin
        if (mul_done) state_d = czs_pkg::StTry;
      end
      czs_pkg::StTry: begin
        if (!cand_over)                    state_d = czs_pkg::StTrySq;
        else if (bit_q == '0)              state_d = czs_pkg::StEmit;
      end
      czs_pkg::StTrySq: begin
        if (mul_done) state_d = czs_pkg::StTryProd;
      end
      czs_pkg::StTryProd: begin
        if (mul_done) state_d = (bit_q == '0) ? czs_pkg::StEmit : czs_pkg::StTry;
      end
      czs_pkg::StEmit: begin
        if (emit_fire) state_d = last_idx ? czs_pkg::StLoad : czs_pkg::StRead;
      end
      default: state_d = czs_pkg::StLoad;
    endcase
  end

  // control outputs and multiplier operands
  always_comb begin
    ram_rd_en     = 1'b0;
    mul_req.valid = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state_q)
      czs_pkg::StRead: ram_rd_en = 1'b1;
      czs_pkg::StSquare: begin
        mul_req.valid = 1'b1;
        mul_req.a     = czs_pkg::MulAW'(mag_q);
        mul_req.b     = czs_pkg::MulBW'(mag_q);
      end
      czs_pkg::StScale: begin
        mul_req.valid = 1'b1;
        mul_req.a     = czs_pkg::MulAW'(sq_q);
        mul_req.b     = k_scale;
      end
      czs_pkg::StTrySq: begin
        mul_req.valid = 1'b1;
        mul_req.a     = czs_pkg::MulAW'(t_odd);
        mul_req.b     = czs_pkg::MulBW'(t_odd);
      end
      czs_pkg::StTryProd: begin
        mul_req.valid = 1'b1;
        mul_req.a     = czs_pkg::MulAW'(ssq_q);
        mul_req.b     = tsq_q;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != czs_pkg::StLoad);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= czs_pkg::StLoad;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cnt_q <= cnt_q + CntW'(1);
        sum_q <= sum_q + SumW'($signed(sample_i[StoreW-1:0]));
      end
      if (emit_fire && last_idx) begin
        cnt_q <= '0;
        sum_q <= '0;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      czs_pkg::StLoad: begin
        if (in_fire && close_col) begin
          idx_q  <= '0;
          pass_q <= 1'b0;
          ssq_q  <= '0;
        end
      end
      czs_pkg::StDev: begin
        mag_q     <= mag_w;
        dev_neg_q <= dev_w[DevW-1];
      end
      czs_pkg::StSquare: begin
        if (mul_done) begin
          sq_q <= mul_prod[SqW-1:0];
          if (!pass_q) begin
            ssq_q <= ssq_next;
            if (last_idx) begin
              idx_q   <= '0;
              pass_q  <= 1'b1;
              degen_q <= (cnt_q < CntW'(2)) || (ssq_next == '0);
            end else begin
              idx_q <= idx_q + AddrW'(1);
            end
          end
        end
      end
      czs_pkg::StScale: begin
        if (mul_done) begin
          rhs_q <= mul_prod;
          v_q   <= '0;
          bit_q <= czs_pkg::ZBitW'(czs_pkg::ZW - 1);
        end
      end
      czs_pkg::StTry: begin
        if (cand_over && bit_q != '0) bit_q <= bit_q - czs_pkg::ZBitW'(1);
      end
      czs_pkg::StTrySq: begin
        if (mul_done) tsq_q <= mul_prod[czs_pkg::MulBW-1:0];
      end
      czs_pkg::StTryProd: begin
        if (mul_done) begin
          if (cand_ok) v_q <= cand;
          if (bit_q != '0) bit_q <= bit_q - czs_pkg::ZBitW'(1);
        end
      end
      czs_pkg::StEmit: begin
        if (emit_fire) begin
          out_z_q     <= degen_q ? '0
                       : (dev_neg_q ? $signed(czs_pkg::ResultW'(0) - v_q) : $signed(v_q));
          out_last_q  <= last_idx;
          out_degen_q <= degen_q;
          if (!last_idx) idx_q <= idx_q + AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  czs_ram #(
    .Width (StoreW),
    .Depth (COLUMN_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (in_fire),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (sample_i[StoreW-1:0]),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (ram_rd_data)
  );

  czs_mul_unit u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign out_valid_o      = out_valid_q;
  assign standardized_o   = out_z_q;
  assign last_of_column_o = out_last_q;
  assign degenerate_o     = out_degen_q;

endmodule

[design/czs_ram.sv]
// generic single-write single-read ram with registered read data
module czs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/czs_mul_unit.sv]
// shared multi-cycle unsigned multiplier, one 16 x 32 slice per cycle
module czs_mul_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  czs_pkg::mul_req_t        req_i,
  output logic                     done_o,
  output logic [czs_pkg::MulPW-1:0] prod_o
);

  localparam int unsigned ChunkCntW = (czs_pkg::MulChunks > 1) ? $clog2(czs_pkg::MulChunks) : 1;
  localparam int unsigned PartW     = czs_pkg::MulChunkW + czs_pkg::MulBW;

  logic                         busy_q;
  logic                         done_q;
  logic [ChunkCntW-1:0]         chunk_q;
  logic [czs_pkg::MulAW-1:0]    a_q;
  logic [czs_pkg::MulBW-1:0]    b_q;
  logic [czs_pkg::MulPW-1:0]    acc_q;
  logic [czs_pkg::MulPW-1:0]    acc_d;
  logic [PartW-1:0]             part;
  logic                         start;

  assign start = req_i.valid && !busy_q && !done_q;

  // most significant slice first, shift the partial sum up each cycle
  assign part  = a_q[czs_pkg::MulAW-1 -: czs_pkg::MulChunkW] * b_q;
  assign acc_d = {acc_q[czs_pkg::MulPW-czs_pkg::MulChunkW-1:0], {czs_pkg::MulChunkW{1'b0}}}
               + czs_pkg::MulPW'(part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q  <= 1'b1;
        chunk_q <= '0;
      end else if (busy_q) begin
        chunk_q <= chunk_q + ChunkCntW'(1);
        if (chunk_q == ChunkCntW'(czs_pkg::MulChunks - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= a_q << czs_pkg::MulChunkW;
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
